/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the lattice walk RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define LWPS_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define LWPS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/lwps_pkg.sv */
// ----------------------------------------------------------------------------
// lwps_pkg
// Shared constants, register codes and control types of the lattice walk step.
// ----------------------------------------------------------------------------
package lwps_pkg;

  // Lattice geometry and counter sizes
  localparam int unsigned NUM_CELLS      = 3;
  localparam int unsigned MAX_UNIT_SITES = 64;
  localparam int unsigned COUNT_BITS     = 24;
  localparam int unsigned PROB_BITS      = 16;

  localparam int unsigned BIN_DEPTH = NUM_CELLS * MAX_UNIT_SITES;
  localparam int unsigned ADDR_W    = $clog2(BIN_DEPTH);

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SITE_W     = 8;
  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned BIN_W      = 24;
  localparam int unsigned PSUM_W     = 40;
  localparam int unsigned SQSUM_W    = 48;
  localparam int unsigned SQ_W       = 2 * SITE_W;
  localparam int unsigned INTRA_W    = 6;
  localparam int unsigned EXTRA_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Unit cell length holds intra + extra, lattice length holds unit * cells
  localparam int unsigned UNIT_W = INTRA_W + 1;
  localparam int unsigned LEN_W  = UNIT_W + $clog2(NUM_CELLS + 1);
  localparam int unsigned CMP_W  = (LEN_W > SITE_W) ? LEN_W : SITE_W;

  localparam logic [DRAW_W-1:0] PROB_MASK = DRAW_W'((64'd1 << PROB_BITS) - 64'd1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTRA_LEN     = 3'd0,
    REG_EXTRA_LEN     = 3'd1,
    REG_P_LEFT_INTRA  = 3'd2,
    REG_P_RIGHT_INTRA = 3'd3,
    REG_P_LEFT_EXTRA  = 3'd4,
    REG_P_RIGHT_EXTRA = 3'd5,
    REG_P_CROSS_OUT   = 3'd6,
    REG_P_CROSS_IN    = 3'd7
  } lwps_reg_e;

  // Register reset values
  localparam logic [INTRA_W-1:0] RST_INTRA_LEN     = 6'd20;
  localparam logic [EXTRA_W-1:0] RST_EXTRA_LEN     = 5'd5;
  localparam logic [DRAW_W-1:0]  RST_P_LEFT_INTRA  = 16'd19661;
  localparam logic [DRAW_W-1:0]  RST_P_RIGHT_INTRA = 16'd19661;
  localparam logic [DRAW_W-1:0]  RST_P_LEFT_EXTRA  = 16'd13107;
  localparam logic [DRAW_W-1:0]  RST_P_RIGHT_EXTRA = 16'd13107;
  localparam logic [DRAW_W-1:0]  RST_P_CROSS_OUT   = 16'd2185;
  localparam logic [DRAW_W-1:0]  RST_P_CROSS_IN    = 16'd3277;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic region;
    logic move;
    logic update;
  } lwps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } lwps_stat_t;

endpackage

/* rtl/core/lattice_walk_particle_step.sv */
// ----------------------------------------------------------------------------
// lattice_walk_particle_step: one lattice random walk step per transaction.
// An accepted transaction passes through the region, move and update states of
// the controller before its result is registered; a new one is taken only in idle.
// A stalled result holds the controller in update and keeps the input stalled.
// Reset loads register defaults and empties histogram and sums at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lattice_walk_particle_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lwps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lwps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lwps_pkg::CMD_W-1:0]         command_i,
  input  logic [lwps_pkg::SITE_W-1:0]        position_i,
  input  logic [lwps_pkg::DRAW_W-1:0]        move_draw_i,
  input  logic [lwps_pkg::DRAW_W-1:0]        cross_draw_i,
  input  logic [lwps_pkg::SITE_W-1:0]        bin_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lwps_pkg::SITE_W-1:0]        new_position_o,
  output logic                               crossed_o,
  output logic                               error_o,
  output logic [lwps_pkg::BIN_W-1:0]         bin_count_o,
  output logic [lwps_pkg::PSUM_W-1:0]        position_sum_o,
  output logic [lwps_pkg::SQSUM_W-1:0]       square_sum_o
);
  import lwps_pkg::*;

  lwps_cmd_t  cmd;
  lwps_stat_t stat;
  logic       in_take;
  logic       out_err;
  logic       out_cross;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  lwps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  lwps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .position_i     (position_i),
    .move_draw_i    (move_draw_i),
    .cross_draw_i   (cross_draw_i),
    .bin_index_i    (bin_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_position_o (new_position_o),
    .crossed_o      (crossed_o),
    .error_o        (error_o),
    .bin_count_o    (bin_count_o),
    .position_sum_o (position_sum_o),
    .square_sum_o   (square_sum_o)
  );

  // Handshake and result qualifiers for the checks below
  assign in_take   = in_valid_i && !in_stall_o;
  assign out_err   = out_valid_o && error_o;
  assign out_cross = out_valid_o && crossed_o;

  // An accepted transaction blocks input through region, move and update
  `LWPS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_take, in_stall_o [*3], "step overlap")
  // A new result only appears out of the update step
  `LWPS_ASSERT_IMPL(a_out_step, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "stray result")
  // An out-of-range transaction carries no bin count
  `LWPS_ASSERT_IMPL(a_error_no_count, clk_i, rst_ni, out_err, bin_count_o == '0, "count on error")
  // A refused move never reports a crossing
  `LWPS_ASSERT_IMPL(a_cross_no_error, clk_i, rst_ni, out_cross, !error_o, "cross on error")

endmodule

/* rtl/core/lwps_ram.sv */
// ----------------------------------------------------------------------------
// lwps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lwps_ctrl.sv */
// ----------------------------------------------------------------------------
// lwps_ctrl
// Step sequencer: accept, locate in unit cell, choose move, update and emit.
// ----------------------------------------------------------------------------
module lwps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lwps_pkg::lwps_stat_t stat_i,
  output logic                in_stall_o,
  output lwps_pkg::lwps_cmd_t  cmd_o
);
  import lwps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REGION,
    ST_MOVE,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REGION;
        end
      end
      ST_REGION: begin
        cmd_o.region = 1'b1;
        state_d      = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/lwps_dp.sv */
// ----------------------------------------------------------------------------
// lwps_dp
// Datapath: registers, region lookup, move choice, histogram and sums.
// ----------------------------------------------------------------------------
module lwps_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lwps_pkg::lwps_cmd_t                 cmd_i,
  output lwps_pkg::lwps_stat_t                stat_o,
  input  logic                                cfg_valid_i,
  input  logic [lwps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lwps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lwps_pkg::CMD_W-1:0]          command_i,
  input  logic [lwps_pkg::SITE_W-1:0]         position_i,
  input  logic [lwps_pkg::DRAW_W-1:0]         move_draw_i,
  input  logic [lwps_pkg::DRAW_W-1:0]         cross_draw_i,
  input  logic [lwps_pkg::SITE_W-1:0]         bin_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lwps_pkg::SITE_W-1:0]         new_position_o,
  output logic                                crossed_o,
  output logic                                error_o,
  output logic [lwps_pkg::BIN_W-1:0]          bin_count_o,
  output logic [lwps_pkg::PSUM_W-1:0]         position_sum_o,
  output logic [lwps_pkg::SQSUM_W-1:0]        square_sum_o
);
  import lwps_pkg::*;

  // Configuration registers
  logic [INTRA_W-1:0] intra_len_q;
  logic [EXTRA_W-1:0] extra_len_q;
  logic [DRAW_W-1:0]  p_left_intra_q, p_right_intra_q;
  logic [DRAW_W-1:0]  p_left_extra_q, p_right_extra_q;
  logic [DRAW_W-1:0]  p_cross_out_q, p_cross_in_q;

  // Input transaction registers
  logic [CMD_W-1:0]  cmd_q;
  logic [SITE_W-1:0] pos_q, bidx_q;
  logic [DRAW_W-1:0] mdraw_q, cdraw_q;

  // Region stage
  logic [UNIT_W-1:0] offset_q, offset_d;
  logic              in_lat_q, in_lat_d;
  logic              bidx_ok_q, bidx_ok_d;
  logic              at_left_q, at_left_d;
  logic              at_right_q, at_right_d;
  logic              from_intra_q, from_intra_d;

  // Move stage
  logic [SITE_W-1:0] next_q, next_d;
  logic              crossed_q, crossed_d;
  logic              hit_q;
  logic [ADDR_W-1:0] raddr;

  // Histogram and sums
  logic [BIN_DEPTH-1:0]  bin_vld_q;
  logic [COUNT_BITS-1:0] ram_rdata, count, count_inc;
  logic                  ram_we;
  logic [ADDR_W-1:0]     waddr;
  logic [PSUM_W-1:0]     psum_q, psum_new;
  logic [SQSUM_W-1:0]    sqsum_q, sqsum_new;
  logic [PSUM_W:0]       psum_ext;
  logic [SQSUM_W:0]      sqsum_ext;
  logic [SQ_W-1:0]       sq;
  logic                  mv_ok;

  // Output register
  logic                out_valid_q;
  logic [SITE_W-1:0]   out_pos_q, out_pos_d;
  logic                out_crossed_q, out_crossed_d;
  logic                out_error_q, out_error_d;
  logic [BIN_W-1:0]    out_bin_q, out_bin_d;
  logic [PSUM_W-1:0]   out_psum_q, out_psum_d;
  logic [SQSUM_W-1:0]  out_sqsum_q, out_sqsum_d;

  // Geometry derived from the registers
  logic [INTRA_W-1:0] intra_sites;
  logic [EXTRA_W-1:0] extra_sites;
  logic [UNIT_W-1:0]  unit, unit_m1, intra_u;
  logic [CMP_W-1:0]   len_full, len;

  assign intra_sites = (intra_len_q == '0) ? INTRA_W'(1) : intra_len_q;
  assign extra_sites = (extra_len_q == '0) ? EXTRA_W'(1) : extra_len_q;
  assign intra_u     = UNIT_W'(intra_sites);
  assign unit        = intra_u + UNIT_W'(extra_sites);
  assign unit_m1     = unit - UNIT_W'(1);
  assign len_full    = CMP_W'(unit) * CMP_W'(NUM_CELLS);
  assign len         = (len_full > CMP_W'(BIN_DEPTH)) ? CMP_W'(BIN_DEPTH) : len_full;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intra_len_q     <= RST_INTRA_LEN;
      extra_len_q     <= RST_EXTRA_LEN;
      p_left_intra_q  <= RST_P_LEFT_INTRA;
      p_right_intra_q <= RST_P_RIGHT_INTRA;
      p_left_extra_q  <= RST_P_LEFT_EXTRA;
      p_right_extra_q <= RST_P_RIGHT_EXTRA;
      p_cross_out_q   <= RST_P_CROSS_OUT;
      p_cross_in_q    <= RST_P_CROSS_IN;
    end else if (cfg_valid_i) begin
      unique case (lwps_reg_e'(cfg_index_i))
        REG_INTRA_LEN:     intra_len_q     <= cfg_data_i[INTRA_W-1:0];
        REG_EXTRA_LEN:     extra_len_q     <= cfg_data_i[EXTRA_W-1:0];
        REG_P_LEFT_INTRA:  p_left_intra_q  <= cfg_data_i;
        REG_P_RIGHT_INTRA: p_right_intra_q <= cfg_data_i;
        REG_P_LEFT_EXTRA:  p_left_extra_q  <= cfg_data_i;
        REG_P_RIGHT_EXTRA: p_right_extra_q <= cfg_data_i;
        REG_P_CROSS_OUT:   p_cross_out_q   <= cfg_data_i;
        REG_P_CROSS_IN:    p_cross_in_q    <= cfg_data_i;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      pos_q   <= position_i;
      mdraw_q <= move_draw_i & PROB_MASK;
      cdraw_q <= cross_draw_i & PROB_MASK;
      bidx_q  <= bin_index_i;
    end
  end

  // Locate the site within its unit cell by comparing against cell starts
  always_comb begin
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cand;
    logic [CMP_W-1:0] base;
    pos_x = CMP_W'(pos_q);
    base  = '0;
    for (int c = 1; c < NUM_CELLS; c++) begin
      cand = CMP_W'(unit) * CMP_W'(c);
      if (pos_x >= cand) begin
        base = cand;
      end
    end
    offset_d     = UNIT_W'(pos_x - base);
    in_lat_d     = pos_x < len;
    bidx_ok_d    = CMP_W'(bidx_q) < len;
    at_left_d    = pos_q == '0;
    at_right_d   = (pos_x + CMP_W'(1)) >= len;
    from_intra_d = offset_d < intra_u;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.region) begin
      offset_q     <= offset_d;
      in_lat_q     <= in_lat_d;
      bidx_ok_q    <= bidx_ok_d;
      at_left_q    <= at_left_d;
      at_right_q   <= at_right_d;
      from_intra_q <= from_intra_d;
    end
  end

  // Choose left, right or stay, then apply the crossing draw
  always_comb begin
    logic [DRAW_W-1:0] pl, pr, pc;
    logic [DRAW_W:0]   thr_r;
    logic              go_left, go_right, has_tgt, to_intra, is_cross, cross_ok;
    logic [UNIT_W-1:0] tgt_off;
    logic [SITE_W-1:0] tgt_pos;
    pl       = (from_intra_q ? p_left_intra_q : p_left_extra_q) & PROB_MASK;
    pr       = (from_intra_q ? p_right_intra_q : p_right_extra_q) & PROB_MASK;
    pc       = (from_intra_q ? p_cross_out_q : p_cross_in_q) & PROB_MASK;
    thr_r    = {1'b0, pl} + {1'b0, pr};
    go_left  = mdraw_q < pl;
    go_right = !go_left && ({1'b0, mdraw_q} < thr_r);
    has_tgt  = (go_left && !at_left_q) || (go_right && !at_right_q);
    if (go_left) begin
      tgt_off = (offset_q == '0) ? unit_m1 : offset_q - UNIT_W'(1);
      tgt_pos = pos_q - SITE_W'(1);
    end else begin
      tgt_off = (offset_q == unit_m1) ? '0 : offset_q + UNIT_W'(1);
      tgt_pos = pos_q + SITE_W'(1);
    end
    to_intra  = tgt_off < intra_u;
    is_cross  = to_intra != from_intra_q;
    cross_ok  = cdraw_q < pc;
    next_d    = (has_tgt && (!is_cross || cross_ok)) ? tgt_pos : pos_q;
    crossed_d = has_tgt && is_cross && cross_ok;
  end

  // Histogram read address: requested bin on a read, new site on a move
  always_comb begin
    if (cmd_q == CMD_READ) begin
      raddr = bidx_ok_q ? ADDR_W'(bidx_q) : '0;
    end else begin
      raddr = in_lat_q ? ADDR_W'(next_d) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.move) begin
      next_q    <= next_d;
      crossed_q <= crossed_d;
      hit_q     <= bin_vld_q[raddr];
    end
  end

  lwps_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (count_inc),
    .re_i    (cmd_i.move),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Saturating bin increment; a bin never written since clear reads zero
  assign count     = hit_q ? ram_rdata : '0;
  assign count_inc = (count == {COUNT_BITS{1'b1}}) ? count : count + COUNT_BITS'(1);
  assign mv_ok     = (cmd_q == CMD_MOVE) && in_lat_q;
  assign ram_we    = cmd_i.update && mv_ok;
  assign waddr     = ADDR_W'(next_q);

  // Saturating sums
  assign sq        = SQ_W'(next_q) * SQ_W'(next_q);
  assign psum_ext  = {1'b0, psum_q} + (PSUM_W + 1)'(next_q);
  assign sqsum_ext = {1'b0, sqsum_q} + (SQSUM_W + 1)'(sq);
  assign psum_new  = psum_ext[PSUM_W] ? '1 : psum_ext[PSUM_W-1:0];
  assign sqsum_new = sqsum_ext[SQSUM_W] ? '1 : sqsum_ext[SQSUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      psum_q    <= '0;
      sqsum_q   <= '0;
    end else if (cmd_i.update) begin
      if (cmd_q == CMD_CLEAR) begin
        bin_vld_q <= '0;
        psum_q    <= '0;
        sqsum_q   <= '0;
      end else if (mv_ok) begin
        bin_vld_q[waddr] <= 1'b1;
        psum_q           <= psum_new;
        sqsum_q          <= sqsum_new;
      end
    end
  end

  // Result fields per command
  always_comb begin
    out_pos_d     = '0;
    out_crossed_d = 1'b0;
    out_error_d   = 1'b0;
    out_bin_d     = '0;
    out_psum_d    = '0;
    out_sqsum_d   = '0;
    case (cmd_q)
      CMD_MOVE: begin
        if (in_lat_q) begin
          out_pos_d     = next_q;
          out_crossed_d = crossed_q;
          out_psum_d    = psum_new;
          out_sqsum_d   = sqsum_new;
        end else begin
          out_pos_d   = pos_q;
          out_error_d = 1'b1;
        end
      end
      CMD_READ: begin
        out_error_d = !bidx_ok_q;
        out_bin_d   = bidx_ok_q ? BIN_W'(count) : '0;
        out_psum_d  = psum_q;
        out_sqsum_d = sqsum_q;
      end
      default: begin
        out_pos_d = '0;
      end
    endcase
  end

  // Output register: load on update, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_pos_q     <= out_pos_d;
      out_crossed_q <= out_crossed_d;
      out_error_q   <= out_error_d;
      out_bin_q     <= out_bin_d;
      out_psum_q    <= out_psum_d;
      out_sqsum_q   <= out_sqsum_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign new_position_o = out_pos_q;
  assign crossed_o      = out_crossed_q;
  assign error_o        = out_error_q;
  assign bin_count_o    = out_bin_q;
  assign position_sum_o = out_psum_q;
  assign square_sum_o   = out_sqsum_q;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: lattice walk particle step
// A table of directed transactions (register defaults, lattice ends,
// boundary crossings, draw thresholds, clear, unused command) is followed by
// random particle walks under several register settings. Each result is checked
// field by field against an in-bench model of the walk, histogram and saturating
// sums, or against typed values; inputs idle and results stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import lwps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RESET_CYCLES     = 7;
  localparam int unsigned DIRECTED_ROWS    = 23;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned ITEMS_PER_PHASE  = 72;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned LONG_HOLD_AT     = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned WATCHDOG_LIMIT   = 1000;
  localparam int unsigned PRINT_LIMIT      = 200;

  localparam longint unsigned PSUM_LIMIT  = (64'd1 << PSUM_W) - 64'd1;
  localparam longint unsigned SQSUM_LIMIT = (64'd1 << SQSUM_W) - 64'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SITE_W-1:0] position;
    logic [DRAW_W-1:0] move_draw;
    logic [DRAW_W-1:0] cross_draw;
    logic [SITE_W-1:0] bin_index;
  } walk_item_t;

  typedef struct packed {
    logic [SITE_W-1:0]  new_position;
    logic               crossed;
    logic               error;
    logic [BIN_W-1:0]   bin_count;
    logic [PSUM_W-1:0]  position_sum;
    logic [SQSUM_W-1:0] square_sum;
  } walk_result_t;

  typedef struct packed {
    walk_item_t   item;
    logic         typed;
    walk_result_t want;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      command_i;
  logic [SITE_W-1:0]     position_i;
  logic [DRAW_W-1:0]     move_draw_i;
  logic [DRAW_W-1:0]     cross_draw_i;
  logic [SITE_W-1:0]     bin_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [SITE_W-1:0]     new_position_o;
  logic                  crossed_o;
  logic                  error_o;
  logic [BIN_W-1:0]      bin_count_o;
  logic [PSUM_W-1:0]     position_sum_o;
  logic [SQSUM_W-1:0]    square_sum_o;

  lattice_walk_particle_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .move_draw_i    (move_draw_i),
    .cross_draw_i   (cross_draw_i),
    .bin_index_i    (bin_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_position_o (new_position_o),
    .crossed_o      (crossed_o),
    .error_o        (error_o),
    .bin_count_o    (bin_count_o),
    .position_sum_o (position_sum_o),
    .square_sum_o   (square_sum_o)
  );

  // Model state: register copies, density histogram and running sums
  logic [CFG_DATA_W-1:0] cfg_shadow [8];
  logic [BIN_W-1:0]      density_tally [BIN_DEPTH];
  longint unsigned       position_total;
  longint unsigned       square_total;

  walk_result_t expected_steps [$];
  step_row_t    directed_rows [DIRECTED_ROWS];
  int unsigned  mismatch_count;
  int unsigned  items_sent;
  int unsigned  results_taken;
  int unsigned  idle_cycles;

  // Free-running clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Geometry of the lattice under the current register copies
  function automatic int unsigned intra_sites();
    return (cfg_shadow[REG_INTRA_LEN] == 0) ? 1 : int'(cfg_shadow[REG_INTRA_LEN]);
  endfunction

  function automatic int unsigned unit_sites();
    int unsigned extra;
    extra = (cfg_shadow[REG_EXTRA_LEN] == 0) ? 1 : int'(cfg_shadow[REG_EXTRA_LEN]);
    return intra_sites() + extra;
  endfunction

  function automatic int unsigned lattice_sites();
    int unsigned len_sites;
    len_sites = unit_sites() * NUM_CELLS;
    return (len_sites > BIN_DEPTH) ? BIN_DEPTH : len_sites;
  endfunction

  function automatic logic site_is_intra(int unsigned site);
    return (site % unit_sites()) < intra_sites();
  endfunction

  function automatic int unsigned prob_of(lwps_reg_e idx);
    return int'(cfg_shadow[idx] & PROB_MASK);
  endfunction

  // Keep only the implemented bits of a register write
  function automatic void store_config(int unsigned idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_INTRA_LEN: cfg_shadow[idx] = CFG_DATA_W'(data[INTRA_W-1:0]);
      REG_EXTRA_LEN: cfg_shadow[idx] = CFG_DATA_W'(data[EXTRA_W-1:0]);
      default:       cfg_shadow[idx] = data;
    endcase
  endfunction

  // Advance the walk model by one transaction and return its result
  function automatic walk_result_t walk_predict(walk_item_t it);
    walk_result_t r;
    int unsigned  len_sites, md, cd, pl, pr, pc, target, landing;
    logic         from_intra, moving;
    r = '0;
    len_sites = lattice_sites();
    md = int'(it.move_draw & PROB_MASK);
    cd = int'(it.cross_draw & PROB_MASK);
    case (it.command)
      CMD_MOVE: begin
        if (it.position >= len_sites) begin
          r.new_position = it.position;
          r.error = 1'b1;
        end else begin
          from_intra = site_is_intra(it.position);
          pl = from_intra ? prob_of(REG_P_LEFT_INTRA) : prob_of(REG_P_LEFT_EXTRA);
          pr = from_intra ? prob_of(REG_P_RIGHT_INTRA) : prob_of(REG_P_RIGHT_EXTRA);
          target = it.position;
          moving = 1'b0;
          if (md < pl) begin
            if (it.position > 0) begin
              target = it.position - 1;
              moving = 1'b1;
            end
          end else if (md < pl + pr) begin
            if (it.position + 1 < len_sites) begin
              target = it.position + 1;
              moving = 1'b1;
            end
          end
          landing = it.position;
          if (moving) begin
            if (site_is_intra(target) == from_intra) begin
              landing = target;
            end else begin
              pc = from_intra ? prob_of(REG_P_CROSS_OUT) : prob_of(REG_P_CROSS_IN);
              if (cd < pc) begin
                landing = target;
                r.crossed = 1'b1;
              end
            end
          end
          // Accumulate with saturation
          if (density_tally[landing] != '1) density_tally[landing] += 1'b1;
          if (position_total + landing > PSUM_LIMIT) position_total = PSUM_LIMIT;
          else position_total += landing;
          if (square_total + landing * landing > SQSUM_LIMIT) square_total = SQSUM_LIMIT;
          else square_total += landing * landing;
          r.new_position = SITE_W'(landing);
          r.position_sum = PSUM_W'(position_total);
          r.square_sum = SQSUM_W'(square_total);
        end
      end
      CMD_READ: begin
        if (it.bin_index >= len_sites) r.error = 1'b1;
        else r.bin_count = density_tally[it.bin_index];
        r.position_sum = PSUM_W'(position_total);
        r.square_sum = SQSUM_W'(square_total);
      end
      CMD_CLEAR: begin
        foreach (density_tally[i]) density_tally[i] = '0;
        position_total = 0;
        square_total = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Directed rows: checked by the model, or typed where obvious
  function automatic step_row_t ask(logic [CMD_W-1:0] cmd, int unsigned pos,
                                    int unsigned md, int unsigned cd, int unsigned bi);
    step_row_t r;
    r = '0;
    r.item.command = cmd;
    r.item.position = SITE_W'(pos);
    r.item.move_draw = DRAW_W'(md);
    r.item.cross_draw = DRAW_W'(cd);
    r.item.bin_index = SITE_W'(bi);
    return r;
  endfunction

  function automatic step_row_t ask_typed(logic [CMD_W-1:0] cmd, int unsigned pos,
                                          int unsigned md, int unsigned cd,
                                          int unsigned bi, int unsigned np, logic err);
    step_row_t r;
    r = ask(cmd, pos, md, cd, bi);
    r.typed = 1'b1;
    r.want.new_position = SITE_W'(np);
    r.want.error = err;
    return r;
  endfunction

  // Random transaction, mostly continuing the particle's walk
  function automatic walk_item_t random_step(logic [SITE_W-1:0] walker);
    walk_item_t  it;
    int unsigned pick, len_sites, base, site;
    len_sites = lattice_sites();
    it.command = CMD_MOVE;
    it.position = walker;
    it.move_draw = DRAW_W'($urandom_range(0, 65535));
    it.cross_draw = $urandom_range(0, 1) ? DRAW_W'($urandom_range(0, 65535))
                                         : DRAW_W'($urandom_range(0, 8191));
    it.bin_index = SITE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // continue the walk
    end else if (pick < 70) begin
      // land on either side of a region boundary
      base = $urandom_range(0, NUM_CELLS - 1) * unit_sites();
      if ($urandom_range(0, 1)) base += intra_sites();
      site = (base == 0) ? $urandom_range(0, 1) : base - 1 + $urandom_range(0, 1);
      if (site >= len_sites) site = len_sites - 1;
      it.position = SITE_W'(site);
    end else if (pick < 80) begin
      it.command = CMD_READ;
      it.bin_index = SITE_W'($urandom_range(0, len_sites - 1));
    end else if (pick < 85) begin
      it.command = CMD_READ;
    end else if (pick < 89) begin
      it.position = SITE_W'($urandom_range(0, 255));
    end else if (pick < 91) begin
      it.command = CMD_CLEAR;
    end else if (pick < 93) begin
      it.command = CMD_UNUSED;
    end else begin
      it.position = SITE_W'($urandom_range(0, len_sites - 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Offer one transaction, hold it until accepted, then log its result
  task automatic send_step(walk_item_t it, logic typed, walk_result_t typed_want,
                           output walk_result_t want);
    int unsigned gap;
    gap = ((items_sent / 50) % 3 == 1) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.command;
    position_i <= it.position;
    move_draw_i <= it.move_draw;
    cross_draw_i <= it.cross_draw;
    bin_index_i <= it.bin_index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = walk_predict(it);
    expected_steps.push_back(typed ? typed_want : want);
    items_sent++;
  endtask

  // Drain, then program all registers for the given phase
  task automatic apply_phase(int unsigned phase);
    logic [CFG_DATA_W-1:0] vals [8];
    in_valid_i <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    // Values in register index order
    case (phase)
      1: vals = '{16'd0, 16'd0, 16'd32768, 16'd32767, 16'd0, 16'd65535, 16'd65535, 16'd0};
      2: vals = '{16'd48, 16'd16, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535};
      3: vals = '{default: 16'hFFFF};
      4: foreach (vals[i]) vals[i] = CFG_DATA_W'($urandom_range(0, 65535));
      default: begin
        foreach (vals[i]) vals[i] = CFG_DATA_W'($urandom_range(0, 32767));
        vals[REG_INTRA_LEN] = CFG_DATA_W'($urandom_range(1, 48));
        vals[REG_EXTRA_LEN] = CFG_DATA_W'($urandom_range(1, 16));
      end
    endcase
    for (int unsigned idx = 0; idx < 8; idx++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(idx);
      cfg_data_i <= vals[idx];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      store_config(idx, vals[idx]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Compare one accepted result with the oldest pending one
  task automatic check_result();
    walk_result_t want;
    if (expected_steps.size() == 0) begin
      report_mismatch("result with none pending", 64'd1, 64'd0);
    end else begin
      want = expected_steps.pop_front();
      if (new_position_o !== want.new_position)
        report_mismatch("new_position", new_position_o, want.new_position);
      if (crossed_o !== want.crossed)
        report_mismatch("crossed", crossed_o, want.crossed);
      if (error_o !== want.error)
        report_mismatch("error", error_o, want.error);
      if (bin_count_o !== want.bin_count)
        report_mismatch("bin_count", bin_count_o, want.bin_count);
      if (position_sum_o !== want.position_sum)
        report_mismatch("position_sum", position_sum_o, want.position_sum);
      if (square_sum_o !== want.square_sum)
        report_mismatch("square_sum", square_sum_o, want.square_sum);
    end
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: random stalls, a stall-free stretch and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results_taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      else if ((results_taken / 60) % 3 == 2) hold = 0;
      else hold = $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      results_taken++;
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    walk_result_t      want;
    walk_item_t        it;
    logic [SITE_W-1:0] walker;

    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    command_i <= CMD_MOVE;
    position_i <= '0;
    move_draw_i <= '0;
    cross_draw_i <= '0;
    bin_index_i <= '0;
    mismatch_count = 0;
    items_sent = 0;
    results_taken = 0;
    position_total = 0;
    square_total = 0;
    foreach (density_tally[i]) density_tally[i] = '0;
    cfg_shadow[REG_INTRA_LEN] = CFG_DATA_W'(RST_INTRA_LEN);
    cfg_shadow[REG_EXTRA_LEN] = CFG_DATA_W'(RST_EXTRA_LEN);
    cfg_shadow[REG_P_LEFT_INTRA] = RST_P_LEFT_INTRA;
    cfg_shadow[REG_P_RIGHT_INTRA] = RST_P_RIGHT_INTRA;
    cfg_shadow[REG_P_LEFT_EXTRA] = RST_P_LEFT_EXTRA;
    cfg_shadow[REG_P_RIGHT_EXTRA] = RST_P_RIGHT_EXTRA;
    cfg_shadow[REG_P_CROSS_OUT] = RST_P_CROSS_OUT;
    cfg_shadow[REG_P_CROSS_IN] = RST_P_CROSS_IN;

    // Default geometry: 20 intra + 5 extra sites per cell, 75 sites in all
    directed_rows = '{
      ask_typed(CMD_READ, 0, 0, 0, 0, 0, 1'b0),              // empty after reset
      ask_typed(CMD_READ, 0, 0, 0, 75, 0, 1'b1),             // bin past the end
      ask_typed(CMD_READ, 255, 65535, 65535, 255, 0, 1'b1),
      ask_typed(CMD_MOVE, 75, 0, 0, 0, 75, 1'b1),            // site past the end
      ask_typed(CMD_MOVE, 255, 65535, 65535, 255, 255, 1'b1),
      ask_typed(CMD_MOVE, 0, 0, 0, 0, 0, 1'b0),              // left off the lattice
      ask(CMD_MOVE, 74, 65535, 0, 0),                        // stay at the far end
      ask(CMD_MOVE, 74, 13107, 0, 0),                        // right off the lattice
      ask(CMD_MOVE, 19, 19661, 0, 0),                        // leave cell, accepted
      ask(CMD_MOVE, 19, 19661, 2185, 0),                     // leave cell, refused
      ask(CMD_MOVE, 20, 0, 3276, 0),                         // enter cell, accepted
      ask(CMD_MOVE, 20, 0, 3277, 0),                         // enter cell, refused
      ask(CMD_MOVE, 10, 19660, 0, 0),
      ask(CMD_MOVE, 10, 39321, 0, 0),
      ask(CMD_MOVE, 10, 39322, 0, 0),
      ask(CMD_MOVE, 25, 0, 0, 0),
      ask(CMD_MOVE, 24, 13107, 0, 0),
      ask(CMD_READ, 0, 0, 0, 19),
      ask(CMD_READ, 0, 0, 0, 74),
      ask_typed(CMD_UNUSED, 170, 65535, 65535, 170, 0, 1'b0),
      ask_typed(CMD_CLEAR, 255, 65535, 65535, 255, 0, 1'b0),
      ask_typed(CMD_READ, 0, 0, 0, 19, 0, 1'b0),             // empty after clear
      ask(CMD_MOVE, 74, 0, 0, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_step(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want, want);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) apply_phase(phase);
      walker = SITE_W'($urandom_range(0, lattice_sites() - 1));
      repeat (ITEMS_PER_PHASE) begin
        it = random_step(walker);
        send_step(it, 1'b0, '0, want);
        if (it.command == CMD_MOVE && !want.error) walker = want.new_position;
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
